// ===== rtl/assembly_source_tokenizer_macros.svh =====
// Assertion macros shared by the tokenizer modules.
`ifndef ASSEMBLY_SOURCE_TOKENIZER_MACROS_SVH
`define ASSEMBLY_SOURCE_TOKENIZER_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define ASMTOK_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// When the antecedent holds, the consequent must hold in the same cycle.
`define ASMTOK_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// When the antecedent holds, the consequent must hold in the following cycle.
`define ASMTOK_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/asmtok_pkg.sv =====
// Shared types and constants of the assembly source tokenizer.
package asmtok_pkg;

    localparam int POSITION_BITS = 16;
    localparam int OUT_DEPTH     = 4;
    localparam int OUT_PTR_W     = $clog2(OUT_DEPTH);

    localparam logic [3:0] K_IDENT   = 4'd0;
    localparam logic [3:0] K_REG     = 4'd1;
    localparam logic [3:0] K_NUM     = 4'd2;
    localparam logic [3:0] K_COLON   = 4'd3;
    localparam logic [3:0] K_COMMA   = 4'd4;
    localparam logic [3:0] K_DOT     = 4'd5;
    localparam logic [3:0] K_NEWLINE = 4'd6;
    localparam logic [3:0] K_END     = 4'd7;
    localparam logic [3:0] K_ERROR   = 4'd8;

    localparam logic [1:0] E_NONE     = 2'd0;
    localparam logic [1:0] E_OVERFLOW = 2'd1;
    localparam logic [1:0] E_BAD_REG  = 2'd2;
    localparam logic [1:0] E_BAD_BYTE = 2'd3;

    typedef struct packed {
        logic [3:0]  kind;
        logic [15:0] value;
        logic [15:0] tok_line;
        logic [15:0] tok_column;
        logic [15:0] ident_start;
        logic [15:0] ident_length;
        logic [1:0]  error_code;
        logic        last;
    } t_token;

    // Tokens produced by one byte: cnt of them, in order tok0 then tok1.
    typedef struct packed {
        logic [1:0] cnt;
        t_token     tok0;
        t_token     tok1;
    } t_step;

endpackage

// ===== rtl/asmtok_core.sv =====
// Tokenizer state and the per-byte scanning logic.
`include "assembly_source_tokenizer_macros.svh"

module asmtok_core import asmtok_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fire,
    input  logic [7:0] i_ch,
    output t_step      o_step
);

    localparam logic [3:0] M_IDLE     = 4'd0;
    localparam logic [3:0] M_COMMENT  = 4'd1;
    localparam logic [3:0] M_IDENT    = 4'd2;
    localparam logic [3:0] M_REGV     = 4'd3;
    localparam logic [3:0] M_ZERO     = 4'd4;
    localparam logic [3:0] M_DEC      = 4'd5;
    localparam logic [3:0] M_HEX      = 4'd6;
    localparam logic [3:0] M_DONE     = 4'd7;
    localparam logic [3:0] M_ERR_OVF  = 4'd8;
    localparam logic [3:0] M_ERR_REG  = 4'd9;
    localparam logic [3:0] M_ERR_BYTE = 4'd10;

    localparam int PB = POSITION_BITS;
    localparam int LW = (PB > 16) ? PB : 16;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;

    function automatic logic is_dec(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return is_dec(c) || (c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46);
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return is_alpha(c) || is_dec(c) || c == 8'h5F;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return c == 8'h20 || c == 8'h09 || c == 8'h0B || c == 8'h0C || c == 8'h0D;
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] d;
        d = 8'h00;
        if (is_dec(c)) begin
            d = c - 8'h30;
        end else if (c >= 8'h61 && c <= 8'h66) begin
            d = c - 8'h57;
        end else if (c >= 8'h41 && c <= 8'h46) begin
            d = c - 8'h37;
        end
        return d[3:0];
    endfunction

    function automatic t_token mk_tok(input logic [3:0] kind, input logic [15:0] value,
                                      input logic [15:0] ln, input logic [15:0] col,
                                      input logic [15:0] istart, input logic [15:0] ilen,
                                      input logic [1:0] err);
        t_token t;
        t.kind         = kind;
        t.value        = value;
        t.tok_line     = ln;
        t.tok_column   = col;
        t.ident_start  = istart;
        t.ident_length = ilen;
        t.error_code   = err;
        t.last         = 1'b0;
        return t;
    endfunction

    logic [3:0]    r_mode, n_mode;
    logic [15:0]   r_acc, n_acc;
    logic [PB-1:0] r_pos, n_pos;
    logic [15:0]   r_line, n_line;
    logic [15:0]   r_col, n_col;
    logic [PB-1:0] r_spos, n_spos;
    logic [15:0]   r_sline, n_sline;
    logic [15:0]   r_scol, n_scol;

    logic          fresh;
    logic          do_cons;
    logic          e1, e2;
    t_token        t1, t2;
    logic [20:0]   acc_new;
    logic [PB-1:0] len;
    logic [LW-1:0] len_w;
    logic [LW-1:0] spos_w;
    logic [15:0]   ilen_sat;

    assign len      = r_pos - r_spos;
    assign len_w    = LW'(len);
    assign spos_w   = LW'(r_spos);
    assign ilen_sat = (len_w > LW'(16'hFFFF)) ? 16'hFFFF : len_w[15:0];

    // Multiply by the base with shifts, then add the digit.
    assign acc_new = ((r_mode == M_HEX) ? {1'b0, r_acc, 4'b0000}
                                        : ({2'b00, r_acc, 3'b000} + {4'b0000, r_acc, 1'b0}))
                     + 21'(hex_val(i_ch));

    always_comb begin
        n_mode  = r_mode;
        n_acc   = r_acc;
        n_pos   = r_pos;
        n_line  = r_line;
        n_col   = r_col;
        n_spos  = r_spos;
        n_sline = r_sline;
        n_scol  = r_scol;
        fresh   = 1'b1;
        do_cons = 1'b0;
        e1      = 1'b0;
        e2      = 1'b0;
        t1      = '0;
        t2      = '0;

        case (r_mode)
            M_ERR_OVF: begin
                e1    = 1'b1;
                t1    = mk_tok(K_ERROR, 16'd0, r_sline, r_scol, 16'd0, 16'd0, E_OVERFLOW);
                fresh = 1'b0;
            end
            M_ERR_REG: begin
                e1    = 1'b1;
                t1    = mk_tok(K_ERROR, 16'd0, r_sline, r_scol, 16'd0, 16'd0, E_BAD_REG);
                fresh = 1'b0;
            end
            M_ERR_BYTE: begin
                e1    = 1'b1;
                t1    = mk_tok(K_ERROR, 16'd0, r_sline, r_scol, 16'd0, 16'd0, E_BAD_BYTE);
                fresh = 1'b0;
            end
            M_DONE: begin
                e1    = 1'b1;
                t1    = mk_tok(K_END, 16'd0, r_sline, r_scol, 16'd0, 16'd0, E_NONE);
                fresh = 1'b0;
            end
            M_COMMENT: begin
                if (i_ch != CH_NUL && i_ch != CH_LF) begin
                    do_cons = 1'b1;
                    fresh   = 1'b0;
                end else begin
                    n_mode = M_IDLE;
                end
            end
            M_IDENT: begin
                if (is_word(i_ch)) begin
                    do_cons = 1'b1;
                    fresh   = 1'b0;
                end else begin
                    e1     = 1'b1;
                    t1     = mk_tok(K_IDENT, 16'd0, r_sline, r_scol, spos_w[15:0],
                                    ilen_sat, E_NONE);
                    n_mode = M_IDLE;
                end
            end
            M_REGV: begin
                e1    = 1'b1;
                fresh = 1'b0;
                if (is_hex(i_ch)) begin
                    t1      = mk_tok(K_REG, {12'd0, hex_val(i_ch)}, r_sline, r_scol,
                                     16'd0, 16'd0, E_NONE);
                    do_cons = 1'b1;
                    n_mode  = M_IDLE;
                end else begin
                    t1     = mk_tok(K_ERROR, 16'd0, r_sline, r_scol, 16'd0, 16'd0, E_BAD_REG);
                    n_mode = M_ERR_REG;
                end
            end
            M_ZERO, M_DEC, M_HEX: begin
                if (r_mode == M_ZERO && (i_ch == 8'h78 || i_ch == 8'h58)) begin
                    do_cons = 1'b1;
                    n_mode  = M_HEX;
                    fresh   = 1'b0;
                end else if ((r_mode == M_HEX) ? is_hex(i_ch) : is_dec(i_ch)) begin
                    fresh = 1'b0;
                    if (acc_new > 21'h00FFFF) begin
                        e1     = 1'b1;
                        t1     = mk_tok(K_ERROR, 16'd0, r_sline, r_scol, 16'd0, 16'd0,
                                        E_OVERFLOW);
                        n_mode = M_ERR_OVF;
                    end else begin
                        do_cons = 1'b1;
                        n_acc   = acc_new[15:0];
                        if (r_mode == M_ZERO) begin
                            n_mode = M_DEC;
                        end
                    end
                end else begin
                    e1     = 1'b1;
                    t1     = mk_tok(K_NUM, r_acc, r_sline, r_scol, 16'd0, 16'd0, E_NONE);
                    n_mode = M_IDLE;
                end
            end
            default: begin
                n_mode = M_IDLE;
            end
        endcase

        // The byte starts a new token; its place is the current counters.
        if (fresh) begin
            n_sline = r_line;
            n_scol  = r_col;
            n_spos  = r_pos;
            if (i_ch == CH_NUL) begin
                e2     = 1'b1;
                t2     = mk_tok(K_END, 16'd0, r_line, r_col, 16'd0, 16'd0, E_NONE);
                n_mode = M_DONE;
            end else if (is_blank(i_ch)) begin
                do_cons = 1'b1;
            end else if (i_ch == CH_SEMI) begin
                do_cons = 1'b1;
                n_mode  = M_COMMENT;
            end else if (i_ch == CH_LF) begin
                e2      = 1'b1;
                t2      = mk_tok(K_NEWLINE, 16'd0, r_line, r_col, 16'd0, 16'd0, E_NONE);
                do_cons = 1'b1;
            end else if (i_ch == 8'h76 || i_ch == 8'h56) begin
                do_cons = 1'b1;
                n_mode  = M_REGV;
            end else if (is_alpha(i_ch) || i_ch == 8'h5F) begin
                do_cons = 1'b1;
                n_mode  = M_IDENT;
            end else if (i_ch == CH_ZERO) begin
                n_acc   = 16'd0;
                do_cons = 1'b1;
                n_mode  = M_ZERO;
            end else if (is_dec(i_ch)) begin
                n_acc   = {12'd0, hex_val(i_ch)};
                do_cons = 1'b1;
                n_mode  = M_DEC;
            end else if (i_ch == CH_COLON) begin
                e2      = 1'b1;
                t2      = mk_tok(K_COLON, 16'd0, r_line, r_col, 16'd0, 16'd0, E_NONE);
                do_cons = 1'b1;
            end else if (i_ch == CH_COMMA) begin
                e2      = 1'b1;
                t2      = mk_tok(K_COMMA, 16'd0, r_line, r_col, 16'd0, 16'd0, E_NONE);
                do_cons = 1'b1;
            end else if (i_ch == CH_DOT) begin
                e2      = 1'b1;
                t2      = mk_tok(K_DOT, 16'd0, r_line, r_col, 16'd0, 16'd0, E_NONE);
                do_cons = 1'b1;
            end else begin
                e2     = 1'b1;
                t2     = mk_tok(K_ERROR, 16'd0, r_line, r_col, 16'd0, 16'd0, E_BAD_BYTE);
                n_mode = M_ERR_BYTE;
            end
        end

        if (do_cons) begin
            n_pos = r_pos + PB'(1);
            if (i_ch == CH_LF) begin
                n_line = (r_line != 16'hFFFF) ? r_line + 16'd1 : r_line;
                n_col  = 16'd1;
            end else begin
                n_col  = (r_col != 16'hFFFF) ? r_col + 16'd1 : r_col;
            end
        end
    end

    always_comb begin
        o_step = '0;
        if (e1 && e2) begin
            o_step.cnt       = 2'd2;
            o_step.tok0      = t1;
            o_step.tok1      = t2;
            o_step.tok1.last = 1'b1;
        end else if (e1 || e2) begin
            o_step.cnt       = 2'd1;
            o_step.tok0      = e1 ? t1 : t2;
            o_step.tok0.last = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_IDLE;
            r_acc   <= 16'd0;
            r_pos   <= '0;
            r_line  <= 16'd1;
            r_col   <= 16'd1;
            r_spos  <= '0;
            r_sline <= 16'd1;
            r_scol  <= 16'd1;
        end else if (i_fire) begin
            r_mode  <= n_mode;
            r_acc   <= n_acc;
            r_pos   <= n_pos;
            r_line  <= n_line;
            r_col   <= n_col;
            r_spos  <= n_spos;
            r_sline <= n_sline;
            r_scol  <= n_scol;
        end
    end

    `ASMTOK_ASSERT_IMP(a_pair_closes_token, o_step.cnt == 2'd2, o_step.tok0.kind == K_IDENT || o_step.tok0.kind == K_NUM, "two tokens from one byte must start with a closed identifier or number")
    `ASMTOK_ASSERT_IMP(a_last_on_final, o_step.cnt != 2'd0, (o_step.cnt == 2'd1) ? o_step.tok0.last : (o_step.tok1.last && !o_step.tok0.last), "last flag not on the final token of a byte")
    `ASMTOK_ASSERT_NEXT(a_done_sticks, i_fire && r_mode == M_DONE, r_mode == M_DONE && $stable(r_pos), "end state left or position moved after end")

endmodule

// ===== rtl/asmtok_fifo.sv =====
// Small token queue that takes up to two tokens per cycle and gives one.
`include "assembly_source_tokenizer_macros.svh"

module asmtok_fifo import asmtok_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_step  i_step,
    input  logic   i_pop,
    output logic   o_room,
    output logic   o_valid,
    output t_token o_tok
);

    t_token                 r_mem [OUT_DEPTH];
    logic [OUT_PTR_W-1:0]   r_head, r_tail;
    logic [OUT_PTR_W:0]     r_count;
    logic [1:0]             push_n;
    logic [OUT_PTR_W-1:0]   tail_p1;

    assign push_n  = i_push ? i_step.cnt : 2'd0;
    assign tail_p1 = r_tail + OUT_PTR_W'(1);
    assign o_room  = r_count <= (OUT_PTR_W + 1)'(OUT_DEPTH - 2);
    assign o_valid = r_count != '0;
    assign o_tok   = r_mem[r_head];

    always_ff @(posedge i_clk) begin
        if (push_n != 2'd0) begin
            r_mem[r_tail] <= i_step.tok0;
        end
        if (push_n == 2'd2) begin
            r_mem[tail_p1] <= i_step.tok1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_tail  <= r_tail + OUT_PTR_W'(push_n);
            r_count <= r_count + (OUT_PTR_W + 1)'(push_n) - (OUT_PTR_W + 1)'(i_pop);
            if (i_pop) begin
                r_head <= r_head + OUT_PTR_W'(1);
            end
        end
    end

    `ASMTOK_ASSERT_ALWAYS(a_count_bound, r_count <= (OUT_PTR_W + 1)'(OUT_DEPTH), "token queue count above its depth")
    `ASMTOK_ASSERT_IMP(a_push_room, push_n != 2'd0, o_room, "tokens pushed without room for two")

endmodule

// ===== rtl/assembly_source_tokenizer.sv =====
// Top level of the streaming assembly source tokenizer.
// Source bytes enter one beat per cycle on the slave stream and tokens leave on the
// master stream with their line and column; a byte that closes a pending identifier
// or number and also starts a one-byte token gives two token beats, the second with
// tlast set on it (tlast marks the final token of each byte). The byte is held in an
// input register and scanned into a four-entry token queue, so the sustained rate
// is one byte per cycle as long as the output keeps up; bytes that give two tokens
// need a second output beat, and input stalls while fewer than two queue slots are
// free. Errors and the end of source repeat their token on every later byte until
// reset.
module assembly_source_tokenizer import asmtok_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] ch
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [3:0] kind, [19:4] value, [35:20] tok_line, [51:36] tok_column,
    // [67:52] ident_start, [83:68] ident_length, [85:84] error_code, [87:86] zero
    output logic [87:0] o_m_axis_tdata,
    output logic        o_m_axis_tlast
);

    logic       r_in_valid;
    logic [7:0] r_ch;
    logic       room;
    logic       fire;
    t_step      step;
    t_token     tok;

    assign fire            = r_in_valid && room;
    assign o_s_axis_tready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_ch <= i_s_axis_tdata;
        end
    end

    asmtok_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_ch    (r_ch),
        .o_step  (step)
    );

    asmtok_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fire),
        .i_step  (step),
        .i_pop   (o_m_axis_tvalid && i_m_axis_tready),
        .o_room  (room),
        .o_valid (o_m_axis_tvalid),
        .o_tok   (tok)
    );

    assign o_m_axis_tdata = {2'b00, tok.error_code, tok.ident_length, tok.ident_start,
                             tok.tok_column, tok.tok_line, tok.value, tok.kind};
    assign o_m_axis_tlast = tok.last;

endmodule

// ===== test/asmtok_token_monitor.sv =====
// Token predictor and stream monitor for the assembly source tokenizer testbench.
module asmtok_token_monitor import asmtok_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    input  logic        i_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] ch
    input  logic        i_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [3:0] kind, [19:4] value, [35:20] tok_line, [51:36] tok_column,
    // [67:52] ident_start, [83:68] ident_length, [85:84] error_code, [87:86] zero
    input  logic [87:0] i_m_axis_tdata,
    input  logic        i_m_axis_tlast,
    output int          o_failures,
    output int          o_pending
);

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef enum logic [3:0] {
        SCAN_IDLE,
        SCAN_COMMENT,
        SCAN_IDENT,
        SCAN_REG,
        SCAN_ZERO,
        SCAN_DEC,
        SCAN_HEX,
        SCAN_DONE,
        SCAN_ERROR
    } t_scan_mode;

    t_scan_mode               scan_mode;
    logic [1:0]               held_error;
    int unsigned              number_acc;
    logic [POSITION_BITS-1:0] position;
    logic [POSITION_BITS-1:0] start_position;
    logic [15:0]              line_count;
    logic [15:0]              column_count;
    logic [15:0]              start_line;
    logic [15:0]              start_column;

    t_token expected_tokens[$];
    int     failures;

    function automatic bit is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_letter(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic bit is_hex(input logic [7:0] c);
        return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    function automatic int unsigned digit_value(input logic [7:0] c);
        if (is_digit(c)) return c - "0";
        if (c >= "a" && c <= "f") return c - "a" + 10;
        return c - "A" + 10;
    endfunction

    // Every token carries the place where the current token started.
    function automatic void add_token(input logic [3:0] kind, input logic [15:0] value,
                                      input logic [15:0] istart, input logic [15:0] ilen,
                                      input logic [1:0] err);
        t_token tok;
        tok.kind         = kind;
        tok.value        = value;
        tok.tok_line     = start_line;
        tok.tok_column   = start_column;
        tok.ident_start  = istart;
        tok.ident_length = ilen;
        tok.error_code   = err;
        tok.last         = 1'b0;
        expected_tokens.push_back(tok);
    endfunction

    function automatic void advance(input logic [7:0] c);
        position = position + 1'b1;
        if (c == CH_LF) begin
            if (line_count != 16'hFFFF) line_count = line_count + 1'b1;
            column_count = 16'd1;
        end else if (column_count != 16'hFFFF) begin
            column_count = column_count + 1'b1;
        end
    endfunction

    function automatic void raise_error(input logic [1:0] code);
        scan_mode  = SCAN_ERROR;
        held_error = code;
        add_token(K_ERROR, 16'd0, 16'd0, 16'd0, code);
    endfunction

    task automatic scan_byte(input logic [7:0] c);
        bit                       fresh;
        int unsigned              first;
        int unsigned              base;
        logic [POSITION_BITS-1:0] span;
        t_token                   tail;
        fresh = 1'b1;
        first = expected_tokens.size();
        case (scan_mode)
            SCAN_ERROR: begin
                add_token(K_ERROR, 16'd0, 16'd0, 16'd0, held_error);
                fresh = 1'b0;
            end
            SCAN_DONE: begin
                add_token(K_END, 16'd0, 16'd0, 16'd0, E_NONE);
                fresh = 1'b0;
            end
            SCAN_COMMENT: begin
                if (c != CH_NUL && c != CH_LF) begin
                    advance(c);
                    fresh = 1'b0;
                end else begin
                    scan_mode = SCAN_IDLE;
                end
            end
            SCAN_IDENT: begin
                if (is_digit(c) || is_letter(c) || c == "_") begin
                    advance(c);
                    fresh = 1'b0;
                end else begin
                    // The length wraps with the position counter and then saturates.
                    span = position - start_position;
                    add_token(K_IDENT, 16'd0, 16'(start_position),
                              (span > 65535) ? 16'hFFFF : 16'(span), E_NONE);
                    scan_mode = SCAN_IDLE;
                end
            end
            SCAN_REG: begin
                if (is_hex(c)) begin
                    add_token(K_REG, 16'(digit_value(c)), 16'd0, 16'd0, E_NONE);
                    advance(c);
                    scan_mode = SCAN_IDLE;
                end else begin
                    raise_error(E_BAD_REG);
                end
                fresh = 1'b0;
            end
            SCAN_ZERO, SCAN_DEC, SCAN_HEX: begin
                base = (scan_mode == SCAN_HEX) ? 16 : 10;
                if (scan_mode == SCAN_ZERO && (c == "x" || c == "X")) begin
                    advance(c);
                    scan_mode = SCAN_HEX;
                    fresh = 1'b0;
                end else if ((scan_mode == SCAN_HEX) ? is_hex(c) : is_digit(c)) begin
                    number_acc = number_acc * base + digit_value(c);
                    if (number_acc > 65535) begin
                        raise_error(E_OVERFLOW);
                    end else begin
                        advance(c);
                        if (scan_mode == SCAN_ZERO) scan_mode = SCAN_DEC;
                    end
                    fresh = 1'b0;
                end else begin
                    add_token(K_NUM, 16'(number_acc), 16'd0, 16'd0, E_NONE);
                    scan_mode = SCAN_IDLE;
                end
            end
            default: ;
        endcase

        // A byte that closed a pending token is scanned again as the start of the next one.
        if (fresh) begin
            start_line     = line_count;
            start_column   = column_count;
            start_position = position;
            if (c == CH_NUL) begin
                add_token(K_END, 16'd0, 16'd0, 16'd0, E_NONE);
                scan_mode = SCAN_DONE;
            end else if (c == CH_SPACE || c == CH_TAB || c == CH_VT || c == CH_FF
                         || c == CH_CR) begin
                advance(c);
            end else if (c == ";") begin
                advance(c);
                scan_mode = SCAN_COMMENT;
            end else if (c == CH_LF) begin
                add_token(K_NEWLINE, 16'd0, 16'd0, 16'd0, E_NONE);
                advance(c);
            end else if (c == "v" || c == "V") begin
                advance(c);
                scan_mode = SCAN_REG;
            end else if (is_letter(c) || c == "_") begin
                advance(c);
                scan_mode = SCAN_IDENT;
            end else if (c == "0") begin
                number_acc = 0;
                advance(c);
                scan_mode = SCAN_ZERO;
            end else if (is_digit(c)) begin
                number_acc = c - "0";
                advance(c);
                scan_mode = SCAN_DEC;
            end else if (c == ":" || c == "," || c == ".") begin
                add_token((c == ":") ? K_COLON : ((c == ",") ? K_COMMA : K_DOT),
                          16'd0, 16'd0, 16'd0, E_NONE);
                advance(c);
            end else begin
                raise_error(E_BAD_BYTE);
            end
        end

        if (expected_tokens.size() > first) begin
            tail = expected_tokens.pop_back();
            tail.last = 1'b1;
            expected_tokens.push_back(tail);
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            failures++;
            $display("%0t: token %s mismatch, expected %0d, actual %0d",
                     $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_token head;
        if (!i_rst_n) begin
            scan_mode      = SCAN_IDLE;
            held_error     = E_NONE;
            number_acc     = 0;
            position       = '0;
            start_position = '0;
            line_count     = 16'd1;
            column_count   = 16'd1;
            start_line     = 16'd1;
            start_column   = 16'd1;
            failures       = 0;
            expected_tokens.delete();
        end else begin
            if (i_s_axis_tvalid && i_s_axis_tready) scan_byte(i_s_axis_tdata);
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                if (expected_tokens.size() == 0) begin
                    failures++;
                    $display("%0t: token beat with nothing expected, expected none, actual %h",
                             $time, i_m_axis_tdata);
                end else begin
                    head = expected_tokens.pop_front();
                    check_field("kind", 16'(head.kind), 16'(i_m_axis_tdata[3:0]));
                    check_field("value", head.value, i_m_axis_tdata[19:4]);
                    check_field("tok_line", head.tok_line, i_m_axis_tdata[35:20]);
                    check_field("tok_column", head.tok_column, i_m_axis_tdata[51:36]);
                    check_field("ident_start", head.ident_start, i_m_axis_tdata[67:52]);
                    check_field("ident_length", head.ident_length, i_m_axis_tdata[83:68]);
                    check_field("error_code", 16'(head.error_code),
                                16'(i_m_axis_tdata[85:84]));
                    check_field("padding", 16'd0, 16'(i_m_axis_tdata[87:86]));
                    check_field("tlast", 16'(head.last), 16'(i_m_axis_tlast));
                end
            end
        end
        o_pending  <= expected_tokens.size();
        o_failures <= failures;
    end

endmodule

// ===== test/assembly_source_tokenizer_test.sv =====
// Top of the assembly source tokenizer testbench: clock, reset, source stimulus and verdict.
module assembly_source_tokenizer_test;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int PHASE_BYTES   = 620;
    localparam int LONG_STALL    = 300;
    localparam int DRAIN_CYCLES  = 16;

    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_VT  = 8'h0B;
    localparam logic [7:0] CH_FF  = 8'h0C;
    localparam logic [7:0] CH_CR  = 8'h0D;

    typedef enum int {
        FINISH_END,
        FINISH_OVERFLOW,
        FINISH_BAD_REG,
        FINISH_BAD_BYTE
    } t_finish_kind;

    logic        clk;
    logic        rst_n;
    logic        src_valid;
    logic        src_ready;
    logic [7:0]  src_data;
    logic        sink_valid;
    logic        sink_ready;
    logic [87:0] sink_data;
    logic        sink_last;
    int          failures;
    int          pending;

    int          src_idle_pct   = 17;
    int          sink_idle_pct  = 67;
    int          stall_requests = 0;
    int          stall_served;
    int          stall_left;
    int unsigned sent_count     = 0;
    bit          after_number   = 1'b0;

    string word_chars   = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_";
    string hex_chars    = "0123456789abcdefABCDEF";
    string punct_chars  = ":,.";
    string stray_chars  = "#$@!+-*/()[]<>=?~|&^%";
    string reg_breakers = "gGxXz_:,; \n";

    assembly_source_tokenizer dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (src_valid),
        .o_s_axis_tready (src_ready),
        .i_s_axis_tdata  (src_data),
        .o_m_axis_tvalid (sink_valid),
        .i_m_axis_tready (sink_ready),
        .o_m_axis_tdata  (sink_data),
        .o_m_axis_tlast  (sink_last)
    );

    asmtok_token_monitor token_monitor (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (src_valid),
        .i_s_axis_tready (src_ready),
        .i_s_axis_tdata  (src_data),
        .i_m_axis_tvalid (sink_valid),
        .i_m_axis_tready (sink_ready),
        .i_m_axis_tdata  (sink_data),
        .i_m_axis_tlast  (sink_last),
        .o_failures      (failures),
        .o_pending       (pending)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("TB_ERROR");
        $finish;
    end

    // Token receiver; a requested long stall is counted out here.
    initial begin
        sink_ready <= 1'b0;
        stall_served = 0;
        stall_left = 0;
        forever begin
            @(posedge clk);
            if (stall_left == 0 && stall_served != stall_requests) begin
                stall_served++;
                stall_left = LONG_STALL;
            end
            if (stall_left > 0) begin
                stall_left--;
                sink_ready <= 1'b0;
            end else begin
                sink_ready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    // Valid stays high between back-to-back beats; it only drops for a gap.
    task automatic put_byte(input logic [7:0] b);
        if ($urandom_range(99) < src_idle_pct) begin
            src_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
        end
        src_valid <= 1'b1;
        src_data  <= b;
        do @(posedge clk); while (!src_ready);
        sent_count++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) put_byte(s[i]);
    endtask

    task automatic wait_until_drained();
        src_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    function automatic logic [7:0] blank_char();
        case ($urandom_range(4))
            0: return CH_TAB;
            1: return CH_VT;
            2: return CH_FF;
            3: return CH_CR;
            default: return " ";
        endcase
    endfunction

    // One random lexeme. A number is kept apart from a following word character so that
    // the stream never overflows or turns into a hex prefix by accident.
    task automatic put_lexeme();
        int         pick;
        int         count;
        logic [7:0] ch;
        pick = $urandom_range(99);
        if (pick < 55 && after_number) put_byte(blank_char());
        after_number = 1'b0;
        if (pick < 25) begin
            do ch = word_chars[$urandom_range(62)];
            while ((ch >= "0" && ch <= "9") || ch == "v" || ch == "V");
            put_byte(ch);
            count = ($urandom_range(9) == 0) ? $urandom_range(40, 8) : $urandom_range(6);
            repeat (count) put_byte(word_chars[$urandom_range(62)]);
        end else if (pick < 35) begin
            put_byte($urandom_range(1) ? "v" : "V");
            put_byte(hex_chars[$urandom_range(21)]);
        end else if (pick < 55) begin
            case ($urandom_range(9))
                0, 1, 2, 3: send_text($sformatf("%0d", $urandom_range(999)));
                4: send_text($sformatf("%0d", $urandom_range(1) ? 65535 : $urandom_range(65535)));
                5: send_text($sformatf("0%0d", $urandom_range(99)));
                6, 7: begin
                    send_text($urandom_range(1) ? "0x" : "0X");
                    repeat ($urandom_range(4, 1)) put_byte(hex_chars[$urandom_range(21)]);
                end
                8: send_text($urandom_range(1) ? "0x" : "0X");
                default: put_byte("0");
            endcase
            after_number = 1'b1;
        end else if (pick < 70) begin
            put_byte(punct_chars[$urandom_range(2)]);
        end else if (pick < 85) begin
            repeat ($urandom_range(3, 1)) put_byte(blank_char());
        end else if (pick < 93) begin
            if ($urandom_range(3) == 0) put_byte(CH_CR);
            put_byte(CH_LF);
        end else begin
            put_byte(";");
            repeat ($urandom_range(8)) begin
                do ch = 8'($urandom_range(255, 1)); while (ch == CH_LF);
                put_byte(ch);
            end
            put_byte(CH_LF);
        end
    endtask

    initial begin
        int unsigned  target;
        t_finish_kind how;
        rst_n     <= 1'b0;
        src_valid <= 1'b0;
        src_data  <= 8'd0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Two-token bytes, register and number extremes, an empty hex number and
        // a comment holding high bytes.
        send_text("_a9:v0 Vf.65535,0xFFFF 0x");
        put_byte(CH_CR);
        send_text("7;");
        put_byte(8'hFF);
        put_byte(8'h80);
        put_byte(CH_LF);

        target = sent_count + PHASE_BYTES;
        while (sent_count < target) put_lexeme();
        wait_until_drained();

        src_idle_pct  = 67;
        sink_idle_pct = 17;
        target = sent_count + PHASE_BYTES;
        while (sent_count < target) put_lexeme();
        wait_until_drained();

        src_idle_pct  = 0;
        sink_idle_pct = 0;
        stall_requests++;
        target = sent_count + PHASE_BYTES;
        while (sent_count < target) put_lexeme();

        send_text("v1,");

        // The end of source and every error hold until reset, so only one of them is reached.
        how = t_finish_kind'($urandom_range(3));
        case (how)
            FINISH_END: put_byte(CH_NUL);
            FINISH_OVERFLOW: send_text($urandom_range(1) ? " 65536" : " 0x1fFfF");
            FINISH_BAD_REG: begin
                send_text(" v");
                put_byte(($urandom_range(4) == 0) ? CH_NUL
                                                  : reg_breakers[$urandom_range(10)]);
            end
            default: put_byte($urandom_range(1) ? 8'($urandom_range(255, 128))
                                                : stray_chars[$urandom_range(20)]);
        endcase
        repeat (60) put_byte(8'($urandom_range(255)));

        wait_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (failures == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
